/* rtl/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg
// Shared constants, types and register codes of the summed area table stream.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int DEF_CHANNEL_BITS = 16;

    localparam int NUM_CH      = 4;
    localparam int PORT_PIX_W  = 16;
    localparam int SUM_W       = 40;
    localparam int CFG_W       = 13;
    localparam int CFG_INDEX_W = 1;

    // Reset value of both geometry registers.
    localparam int CFG_DIM_RESET = 4096;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_vec_t;

endpackage

/* rtl/sat_queue.sv */
// ----------------------------------------------------------------------------
// sat_queue
// Small register queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module sat_queue
    import sat_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/sat_front.sv */
// ----------------------------------------------------------------------------
// sat_front
// Holds the frame geometry, tracks the raster position and tags each pixel.
// ----------------------------------------------------------------------------
module sat_front
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PORT_PIX_W-1:0]  s_pixel_red,
    input  logic [PORT_PIX_W-1:0]  s_pixel_green,
    input  logic [PORT_PIX_W-1:0]  s_pixel_blue,
    input  logic [PORT_PIX_W-1:0]  s_pixel_alpha,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [NUM_CH*((CHANNEL_BITS < PORT_PIX_W) ? CHANNEL_BITS : PORT_PIX_W)
                  + $clog2(MAX_WIDTH) + 3 - 1:0] push_data
);

    localparam int PIX_W  = (CHANNEL_BITS < PORT_PIX_W) ? CHANNEL_BITS : PORT_PIX_W;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W  = ($clog2(MAXD + 1) > CFG_W) ? $clog2(MAXD + 1) : CFG_W;

    typedef struct packed {
        logic [NUM_CH-1:0][PIX_W-1:0] pix;
        logic [COL_W-1:0]             col;
        logic                         row_start;
        logic                         first_row;
        logic                         frame_end;
    } item_t;

    // Last valid index of a dimension: zero acts as one, oversize as the maximum.
    function automatic logic [DIM_W-1:0] clamp_last(input logic [DIM_W-1:0] v,
                                                     input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (v > maxv) begin
            r = maxv - 1'b1;
        end else begin
            r = v - 1'b1;
        end
        return r;
    endfunction

    logic [COL_W-1:0] width_last_reg;
    logic [ROW_W-1:0] height_last_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             row_start_reg, row_start_next;
    logic [DIM_W-1:0] cfg_wide;
    logic [DIM_W-1:0] width_clamped, height_clamped;
    logic             accept, row_end, frame_end;
    item_t            item;

    assign cfg_ready  = 1'b1;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    assign cfg_wide       = DIM_W'(cfg_data);
    assign width_clamped  = clamp_last(cfg_wide, DIM_W'(MAX_WIDTH));
    assign height_clamped = clamp_last(cfg_wide, DIM_W'(MAX_HEIGHT));

    assign row_end   = (col_reg >= width_last_reg);
    assign frame_end = row_end && (row_reg >= height_last_reg);

    always_comb begin
        item.pix[0]    = s_pixel_red[PIX_W-1:0];
        item.pix[1]    = s_pixel_green[PIX_W-1:0];
        item.pix[2]    = s_pixel_blue[PIX_W-1:0];
        item.pix[3]    = s_pixel_alpha[PIX_W-1:0];
        item.col       = col_reg;
        item.row_start = row_start_reg;
        item.first_row = (row_reg == '0);
        item.frame_end = frame_end;
    end

    assign push_data = item;

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        row_start_next = row_start_reg;
        if (accept) begin
            row_start_next = row_end;
            if (row_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            row_start_reg   <= 1'b1;
            width_last_reg  <= COL_W'(clamp_last(DIM_W'(CFG_DIM_RESET), DIM_W'(MAX_WIDTH)));
            height_last_reg <= ROW_W'(clamp_last(DIM_W'(CFG_DIM_RESET), DIM_W'(MAX_HEIGHT)));
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_start_reg <= row_start_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_last_reg  <= COL_W'(width_clamped);
                    CFG_FRAME_HEIGHT: height_last_reg <= ROW_W'(height_clamped);
                    default: ;
                endcase
            end
        end
    end

endmodule

/* rtl/sat_back.sv */
// ----------------------------------------------------------------------------
// sat_back
// Running row sums, line store read and write, and the result register.
// ----------------------------------------------------------------------------
module sat_back
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [NUM_CH*((CHANNEL_BITS < PORT_PIX_W) ? CHANNEL_BITS : PORT_PIX_W)
                  + $clog2(MAX_WIDTH) + 3 - 1:0] pop_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SUM_W-1:0]       m_sum_red,
    output logic [SUM_W-1:0]       m_sum_green,
    output logic [SUM_W-1:0]       m_sum_blue,
    output logic [SUM_W-1:0]       m_sum_alpha,
    output logic                   m_frame_end
);

    localparam int PIX_W = (CHANNEL_BITS < PORT_PIX_W) ? CHANNEL_BITS : PORT_PIX_W;
    localparam int COL_W = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic [NUM_CH-1:0][PIX_W-1:0] pix;
        logic [COL_W-1:0]             col;
        logic                         row_start;
        logic                         first_row;
        logic                         frame_end;
    } item_t;

    sum_vec_t line_mem [0:MAX_WIDTH-1];

    item_t            item;
    sum_vec_t         acc_reg, acc_next;
    sum_vec_t         rd_data_reg;
    sum_vec_t         byp_data_reg;
    sum_vec_t         above, sum;
    sum_vec_t         m_sum_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_first_reg;
    logic             s1_fend_reg;
    logic             s1_byp_reg;
    logic             m_valid_reg, m_valid_next;
    logic             m_fend_reg;
    logic             out_en, s1_move, s1_free, pop;

    assign item = pop_data;

    assign out_en    = !m_valid_reg || m_ready;
    assign s1_move   = s1_valid_reg && out_en;
    assign s1_free   = !s1_valid_reg || out_en;
    assign pop_ready = s1_free;
    assign pop       = pop_valid && s1_free;

    // A result written in the same cycle as the read of its column is forwarded.
    assign above = s1_byp_reg ? byp_data_reg : rd_data_reg;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            acc_next[c] = (item.row_start ? '0 : acc_reg[c]) + SUM_W'(item.pix[c]);
            sum[c]      = (s1_first_reg ? '0 : above[c]) + acc_reg[c];
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (pop) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            acc_reg      <= acc_next;
            s1_col_reg   <= item.col;
            s1_first_reg <= item.first_row;
            s1_fend_reg  <= item.frame_end;
            s1_byp_reg   <= s1_move && (s1_col_reg == item.col);
            byp_data_reg <= sum;
        end
        if (s1_move) begin
            m_sum_reg  <= sum;
            m_fend_reg <= s1_fend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            line_mem[s1_col_reg] <= sum;
        end
        if (pop) begin
            rd_data_reg <= line_mem[item.col];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_sum_red   = m_sum_reg[0];
    assign m_sum_green = m_sum_reg[1];
    assign m_sum_blue  = m_sum_reg[2];
    assign m_sum_alpha = m_sum_reg[3];
    assign m_frame_end = m_fend_reg;

endmodule

/* rtl/summed_area_table_stream.sv */
// Path: queue, row sum stage, result register. The line store has one read and one
// write port. Throughput: one pixel per cycle unless m_ready stalls the output.
// Reset: synchronous on aresetn low; clears positions, queue and valids; sets both
// geometry registers for a size of 4096. Row sums and line store are not cleared.
// ----------------------------------------------------------------------------
// summed_area_table_stream
// Streaming summed area table over RGBA pixels in raster order.
// ----------------------------------------------------------------------------
module summed_area_table_stream
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PORT_PIX_W-1:0]  s_pixel_red,
    input  logic [PORT_PIX_W-1:0]  s_pixel_green,
    input  logic [PORT_PIX_W-1:0]  s_pixel_blue,
    input  logic [PORT_PIX_W-1:0]  s_pixel_alpha,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SUM_W-1:0]       m_sum_red,
    output logic [SUM_W-1:0]       m_sum_green,
    output logic [SUM_W-1:0]       m_sum_blue,
    output logic [SUM_W-1:0]       m_sum_alpha,
    output logic                   m_frame_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int PIX_W  = (CHANNEL_BITS < PORT_PIX_W) ? CHANNEL_BITS : PORT_PIX_W;
    localparam int DATA_W = NUM_CH * PIX_W + $clog2(MAX_WIDTH) + 3;

    logic              push_valid, push_ready;
    logic [DATA_W-1:0] push_data;
    logic              pop_valid, pop_ready;
    logic [DATA_W-1:0] pop_data;

    sat_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_red   (s_pixel_red),
        .s_pixel_green (s_pixel_green),
        .s_pixel_blue  (s_pixel_blue),
        .s_pixel_alpha (s_pixel_alpha),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    sat_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sat_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sum_red   (m_sum_red),
        .m_sum_green (m_sum_green),
        .m_sum_blue  (m_sum_blue),
        .m_sum_alpha (m_sum_alpha),
        .m_frame_end (m_frame_end)
    );

endmodule
